FILE: src/pte_pkg.sv
`default_nettype none

package pte_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         exponent;
    logic signed [31:0] coefficient;
    logic signed [31:0] point;
  } item_t;

  typedef struct packed {
    logic signed [31:0] coefficient_now;
    logic signed [63:0] poly_value;
    logic               saturated;
  } result_t;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN  = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD_WR,
    ST_CLEAR,
    ST_EV_READ,
    ST_EV_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_MLO,
    HS_MHI,
    HS_SCALE,
    HS_ADD
  } hstep_t;

endpackage

`default_nettype wire

FILE: src/polynomial_term_store_evaluator_top.sv
// Polynomial store and evaluator. One word in gives one word out. The
// coefficients sit in a single-port-write, registered-read RAM indexed by
// exponent; an add reads, saturates to 32 bits and writes back the entry,
// a clear zeroes the RAM one entry per cycle, and an evaluate walks the RAM
// from the top exponent down through a shared multiply-add unit that forms
// the two 32x32 partial products of the 64x32 Horner multiply in separate
// steps for each coefficient. Items are handled one at a time. After reset
// a clearing pass over every entry runs before the first word is taken.
// Adds beyond the store depth and unused op codes return an all-zero word.
`default_nettype none

module polynomial_term_store_evaluator_top import pte_pkg::*; #(
  parameter int MAX_DEGREE_PLUS_ONE = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AW = $clog2(MAX_DEGREE_PLUS_ONE);
  localparam logic [AW-1:0] TOP_IDX = AW'(MAX_DEGREE_PLUS_ONE - 1);

  state_t state, state_next;

  item_t              held;
  logic [AW-1:0]      idx, idx_next;
  logic signed [63:0] acc;
  logic               sat;
  result_t            res, res_next;
  logic               load_out;
  logic               accept;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  logic               h_start;
  logic               h_done;
  logic signed [63:0] h_acc;
  logic               h_sat;

  logic [AW+5:0]      item_wide;
  logic [AW+5:0]      held_wide;
  logic               in_range;
  logic signed [32:0] sum33;
  logic               over32;
  logic signed [31:0] sat32;

  pte_ram #(
    .WIDTH (32),
    .DEPTH (MAX_DEGREE_PLUS_ONE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pte_horner u_horner (
    .clk     (clk),
    .rst     (rst),
    .start   (h_start),
    .acc     (acc),
    .point   (held.point),
    .coef    (rd_data),
    .done    (h_done),
    .acc_out (h_acc),
    .sat_out (h_sat)
  );

  always_comb begin
    item_wide = {{AW{1'b0}}, item.exponent};
    held_wide = {{AW{1'b0}}, held.exponent};
    in_range  = int'(held.exponent) < MAX_DEGREE_PLUS_ONE;
    sum33     = {rd_data[31], rd_data} + {held.coefficient[31], held.coefficient};
    over32    = sum33[32] != sum33[31];
    if (over32) begin
      sat32 = sum33[32] ? COEF_MIN : COEF_MAX;
    end else begin
      sat32 = sum33[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    item_stall = 1'b1;
    accept     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = '0;
    h_start    = 1'b0;
    res_next   = res;
    load_out   = 1'b0;
    case (state)
      ST_INIT: begin
        wr_en = 1'b1;
        if (idx == TOP_IDX) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          accept   = 1'b1;
          rd_en    = 1'b1;
          rd_addr  = item_wide[AW-1:0];
          res_next = '0;
          case (item.op)
            OP_ADD:   state_next = ST_ADD_WR;
            OP_EVAL: begin
              idx_next   = TOP_IDX;
              state_next = ST_EV_READ;
            end
            OP_CLEAR: begin
              idx_next   = '0;
              state_next = ST_CLEAR;
            end
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD_WR: begin
        if (in_range) begin
          wr_en                    = 1'b1;
          wr_addr                  = held_wide[AW-1:0];
          wr_data                  = sat32;
          res_next.coefficient_now = sat32;
          res_next.saturated       = over32;
        end
        state_next = ST_DONE;
      end
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (idx == TOP_IDX) begin
          idx_next   = '0;
          state_next = ST_DONE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_EV_READ: begin
        rd_en      = 1'b1;
        h_start    = 1'b1;
        state_next = ST_EV_WAIT;
      end
      ST_EV_WAIT: begin
        if (h_done) begin
          if (idx == '0) begin
            res_next.poly_value = h_acc;
            res_next.saturated  = sat | h_sat;
            state_next          = ST_DONE;
          end else begin
            idx_next   = idx - AW'(1);
            state_next = ST_EV_READ;
          end
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      held <= item;
      acc  <= '0;
      sat  <= 1'b0;
    end else if (state == ST_EV_WAIT && h_done) begin
      acc <= h_acc;
      sat <= sat | h_sat;
    end
    if (load_out) begin
      result <= res;
    end
  end

  a_no_write_in_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EV_READ || state == ST_EV_WAIT) |-> !wr_en)
    else $error("store written during evaluation");

  a_add_reports_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_WR && wr_en) |=> (res.coefficient_now == $past(wr_data)
      && res.poly_value == 64'sd0))
    else $error("add result does not match written entry");

  a_eval_walks_all: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EV_WAIT && state_next == ST_DONE) |-> (idx == '0))
    else $error("evaluation ended before exponent zero");

  a_horner_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    h_start |=> !h_done)
    else $error("multiply-add finished too early");

endmodule

`default_nettype wire

FILE: src/pte_ram.sv
`default_nettype none

module pte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/pte_horner.sv
`default_nettype none

module pte_horner import pte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] acc,
  input  logic signed [31:0] point,
  input  logic signed [31:0] coef,
  output logic               done,
  output logic signed [63:0] acc_out,
  output logic               sat_out
);

  hstep_t state, state_next;

  logic               neg;
  logic [63:0]        ma;
  logic [31:0]        mx;
  logic [63:0]        p_lo;
  logic [63:0]        p_hi;
  logic signed [63:0] mul_res;
  logic               mul_sat;

  logic               rnd;
  logic [80:0]        q;
  logic [63:0]        lim;
  logic               over;
  logic signed [63:0] scaled;
  logic signed [63:0] addend;
  logic signed [64:0] sum;
  logic               add_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      HS_IDLE: begin
        if (start) begin
          state_next = HS_MLO;
        end
      end
      HS_MLO:   state_next = HS_MHI;
      HS_MHI:   state_next = HS_SCALE;
      HS_SCALE: state_next = HS_ADD;
      HS_ADD: begin
        done       = 1'b1;
        state_next = HS_IDLE;
      end
      default:  state_next = HS_IDLE;
    endcase
  end

  // floor(acc * x / 2^16) in sign-magnitude form
  always_comb begin
    rnd    = neg && (p_lo[15:0] != 16'd0);
    q      = {1'b0, p_hi, 16'd0} + {33'd0, p_lo[63:16]} + {80'd0, rnd};
    lim    = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    over   = q > {17'd0, lim};
    if (over) begin
      scaled = neg ? ACC_MIN : ACC_MAX;
    end else if (neg) begin
      scaled = ~q[63:0] + 64'd1;
    end else begin
      scaled = q[63:0];
    end
  end

  always_comb begin
    addend   = {{16{coef[31]}}, coef, 16'd0};
    sum      = {mul_res[63], mul_res} + {addend[63], addend};
    add_over = sum[64] != sum[63];
    if (add_over) begin
      acc_out = sum[64] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_out = sum[63:0];
    end
    sat_out = mul_sat | add_over;
  end

  always_ff @(posedge clk) begin
    if (state == HS_IDLE && start) begin
      neg <= acc[63] ^ point[31];
      ma  <= acc[63] ? (~acc + 64'd1) : acc;
      mx  <= point[31] ? (~point + 32'd1) : point;
    end
    if (state == HS_MLO) begin
      p_lo <= 64'(ma[31:0]) * 64'(mx);
    end
    if (state == HS_MHI) begin
      p_hi <= 64'(ma[63:32]) * 64'(mx);
    end
    if (state == HS_SCALE) begin
      mul_res <= scaled;
      mul_sat <= over;
    end
  end

endmodule

`default_nettype wire

FILE: bench/pte_checker.sv
`default_nettype none

module pte_checker import pte_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      n_fail,
  output int      n_open
);

  localparam logic signed [32:0] SUM32_HI = 33'(COEF_MAX);
  localparam logic signed [32:0] SUM32_LO = 33'(COEF_MIN);
  localparam logic signed [95:0] PROD_HI  = 96'(ACC_MAX);
  localparam logic signed [95:0] PROD_LO  = 96'(ACC_MIN);
  localparam logic signed [64:0] SUM64_HI = 65'(ACC_MAX);
  localparam logic signed [64:0] SUM64_LO = 65'(ACC_MIN);

  logic signed [31:0] coef_mem [DEPTH];
  result_t            pending_words [$];
  result_t            want;

  function automatic result_t predict_word(item_t w);
    result_t            r;
    logic signed [32:0] sum;
    logic signed [63:0] acc;
    logic signed [95:0] prod;
    logic signed [95:0] q;
    logic signed [64:0] term;
    logic signed [64:0] s;
    r = '0;
    case (w.op)
      OP_ADD: begin
        sum = 33'($signed(coef_mem[w.exponent])) + 33'($signed(w.coefficient));
        if (sum > SUM32_HI) begin
          sum = SUM32_HI;
          r.saturated = 1'b1;
        end else if (sum < SUM32_LO) begin
          sum = SUM32_LO;
          r.saturated = 1'b1;
        end
        coef_mem[w.exponent] = sum[31:0];
        r.coefficient_now = sum[31:0];
      end
      OP_EVAL: begin
        acc = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
          // floor(acc * x / 2^16) from the exact 96-bit product
          prod = 96'(acc) * 96'($signed(w.point));
          q = prod >>> 16;
          if (q > PROD_HI) begin
            acc = ACC_MAX;
            r.saturated = 1'b1;
          end else if (q < PROD_LO) begin
            acc = ACC_MIN;
            r.saturated = 1'b1;
          end else begin
            acc = q[63:0];
          end
          term = 65'($signed(coef_mem[i]));
          term = term <<< 16;
          s = 65'(acc) + term;
          if (s > SUM64_HI) begin
            acc = ACC_MAX;
            r.saturated = 1'b1;
          end else if (s < SUM64_LO) begin
            acc = ACC_MIN;
            r.saturated = 1'b1;
          end else begin
            acc = s[63:0];
          end
        end
        r.poly_value = acc;
      end
      OP_CLEAR: begin
        foreach (coef_mem[k]) coef_mem[k] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (coef_mem[k]) coef_mem[k] = '0;
      pending_words.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_words.size() == 0) begin
          n_fail++;
          $error("result word with nothing expected");
        end else begin
          want = pending_words.pop_front();
          if (result.coefficient_now !== want.coefficient_now) begin
            n_fail++;
            $error("coefficient_now: expected %0d, actual %0d",
                   $signed(want.coefficient_now), $signed(result.coefficient_now));
          end
          if (result.poly_value !== want.poly_value) begin
            n_fail++;
            $error("poly_value: expected %0d, actual %0d",
                   $signed(want.poly_value), $signed(result.poly_value));
          end
          if (result.saturated !== want.saturated) begin
            n_fail++;
            $error("saturated: expected %0d, actual %0d", want.saturated, result.saturated);
          end
        end
      end
      if (item_valid && !item_stall) pending_words.push_back(predict_word(item));
    end
    n_open = pending_words.size();
  end

endmodule

`default_nettype wire

FILE: bench/tb_polynomial_term_store_evaluator_top.sv
`default_nettype none

module tb_polynomial_term_store_evaluator_top;
  import pte_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS     = 1850;
  localparam int LIMIT     = 3_000_000;
  localparam int DRAIN     = 350;
  localparam int LONG_HOLD = 400;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;
  int      n_fail;
  int      n_open;
  int      cycles       = 0;
  int      n_sent       = 0;
  bit      gaps_on      = 1'b1;
  bit      hold_req     = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  polynomial_term_store_evaluator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  pte_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .n_fail       (n_fail),
    .n_open       (n_open)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3: return $urandom;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_point();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
      default: return $urandom_range(0, 32'h40000) - 32'h20000;
    endcase
  endfunction

  task automatic put(input logic [1:0] op, input logic [5:0] e,
                     input logic signed [31:0] c, input logic signed [31:0] x);
    item_t w;
    w.op          = op;
    w.exponent    = e;
    w.coefficient = c;
    w.point       = x;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (op != OP_UNUSED) n_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // word source
  initial begin
    bit hold_issued;
    bit pause_done;
    hold_issued = 1'b0;
    pause_done  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    put(OP_EVAL, 6'd0, 32'sd0, 32'sh0001_0000);
    put(OP_ADD, 6'd0, 32'sd5, 32'sd0);
    put(OP_ADD, 6'd63, COEF_MAX, 32'sd0);
    put(OP_ADD, 6'd63, 32'sd1, 32'sd0);
    put(OP_ADD, 6'd63, COEF_MIN, 32'sd0);
    put(OP_ADD, 6'd63, 32'sd1, 32'sd0);
    put(OP_ADD, 6'd1, COEF_MIN, 32'sd0);
    put(OP_ADD, 6'd1, -32'sd1, 32'sd0);
    put(OP_ADD, 6'd2, 32'sd3, 32'sd0);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sd0);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sh0001_0000);
    put(OP_EVAL, 6'd0, 32'sd0, -32'sh0001_0000);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sd1);
    put(OP_EVAL, 6'd0, 32'sd0, -32'sd1);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sh7FFF_FFFF);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sh8000_0000);
    put(OP_ADD, 6'd63, COEF_MAX, 32'sd0);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sh7FFF_FFFF);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sh8000_0000);
    put(OP_UNUSED, 6'h3F, -32'sd1, -32'sd1);
    put(OP_CLEAR, 6'h2A, 32'sh5555_AAAA, 32'shAAAA_5555);
    put(OP_EVAL, 6'd0, 32'sd0, 32'sh0001_0000);

    while (n_sent < ITEMS) begin
      if (n_sent >= ITEMS - 200) gaps_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      if (!hold_issued && n_sent >= 300) begin
        hold_req    = 1'b1;
        hold_issued = 1'b1;
      end
      if (!pause_done && n_sent >= 900) begin
        item_valid <= 1'b0;
        @(posedge clk);
        wait (n_open == 0);
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) put(OP_CLEAR, 6'($urandom), $urandom, $urandom);
      repeat ($urandom_range(1, 6)) begin
        put(OP_ADD, ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
            rand_coef(), $urandom);
      end
      repeat ($urandom_range(1, 3)) put(OP_EVAL, 6'($urandom), $urandom, rand_point());
      if ($urandom_range(0, 9) == 0) put(OP_UNUSED, 6'($urandom), $urandom, $urandom);
    end

    item_valid <= 1'b0;
    @(posedge clk);
    wait (n_open == 0);
    repeat (DRAIN) @(posedge clk);
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // result sink back-pressure
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim.f
src/pte_pkg.sv
src/pte_ram.sv
src/pte_horner.sv
src/polynomial_term_store_evaluator_top.sv
bench/pte_checker.sv
bench/tb_polynomial_term_store_evaluator_top.sv
